/* hdl/bsar_pkg.sv */
`timescale 1ns / 1ps

package bsar_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_TARGET_SPEED = 3'd0,
    CFG_TARGET_ACCEL = 3'd1,
    CFG_ACCEL_MODE   = 3'd2,
    CFG_AUTO_ROTATE  = 3'd3,
    CFG_IGNORE_FAULT = 3'd4
  } cfg_idx_e;

  localparam logic [3:0]        FaultHoldLoad = 4'd10;
  localparam logic signed [7:0] TorqueAngle   = 8'sd64;
  localparam logic [7:0]        DutyBase      = 8'h40;
  localparam logic [7:0]        DutyLimit     = 8'hC0;
  localparam logic [5:0]        StallReload   = 6'd32;

  typedef struct packed {
    logic signed [15:0] target_speed;
    logic signed [15:0] target_accel;
    logic               accel_mode;
    logic               auto_rotate;
    logic               ignore_fault;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        last_position;
    logic signed [20:0] speed_acc;
    logic [15:0]        last_speed_low;
    logic signed [15:0] accel_acc;
    logic [5:0]         stall_count;
    logic [3:0]         fault_hold;
  } state_t;

  typedef struct packed {
    logic               pwm_update;
    logic [7:0]         pwm_duty;
    logic signed [7:0]  motor_action;
    logic               kick_step;
    logic               motor_off;
    logic signed [15:0] speed;
    logic signed [15:0] accel;
  } result_t;

endpackage

/* hdl/bsar_cfg_if.sv */
`timescale 1ns / 1ps

interface bsar_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/bsar_in_if.sv */
`timescale 1ns / 1ps

interface bsar_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] position;
  logic        sensor_detecting;
  logic        fault_event;
  logic        fault_line_low;

  modport source (output valid, output position, output sensor_detecting,
                  output fault_event, output fault_line_low, input ready);
  modport sink (input valid, input position, input sensor_detecting,
                input fault_event, input fault_line_low, output ready);
endinterface

/* hdl/bsar_out_if.sv */
`timescale 1ns / 1ps

interface bsar_out_if;
  logic               valid;
  logic               ready;
  logic               pwm_update;
  logic [7:0]         pwm_duty;
  logic signed [7:0]  motor_action;
  logic               kick_step;
  logic               motor_off;
  logic signed [15:0] speed;
  logic signed [15:0] accel;

  modport source (output valid, output pwm_update, output pwm_duty, output motor_action,
                  output kick_step, output motor_off, output speed, output accel,
                  input ready);
  modport sink (input valid, input pwm_update, input pwm_duty, input motor_action,
                input kick_step, input motor_off, input speed, input accel,
                output ready);
endinterface

/* hdl/bldc_speed_accel_regulator.sv */
`timescale 1ns / 1ps
// result: registered, it appears in the cycle after its tick is accepted
// throughput: one tick per cycle while the sink keeps taking results; the tick state
// register loads on each accepted tick and the result register frees as soon as the sink takes its transaction
// reset: rst_ni asynchronous active low clears configuration, averaging state,
// stall and fault counters and the result valid flag

module bldc_speed_accel_regulator (
  input  logic      clk_i,
  input  logic      rst_ni,
  bsar_cfg_if.sink  cfg_i,
  bsar_in_if.sink   in_i,
  bsar_out_if.source out_o
);

  bsar_pkg::cfg_t    cfg;
  bsar_pkg::state_t  state_q;
  bsar_pkg::state_t  state_d;
  bsar_pkg::result_t result_d;
  logic              stage_ready;
  logic              in_accept;

  assign in_i.ready = stage_ready;
  assign in_accept  = in_i.valid && stage_ready;

  bsar_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  bsar_datapath u_datapath (
    .cfg_i              (cfg),
    .state_i            (state_q),
    .position_i         (in_i.position),
    .sensor_detecting_i (in_i.sensor_detecting),
    .fault_event_i      (in_i.fault_event),
    .fault_line_low_i   (in_i.fault_line_low),
    .state_o            (state_d),
    .result_o           (result_d)
  );

  bsar_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (in_accept),
    .result_i (result_d),
    .ready_o  (stage_ready),
    .out_o    (out_o)
  );

  // regulator state advances once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_accept) begin
      state_q <= state_d;
    end
  end

  // sensing ticks give a result without a pwm update
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_i.sensor_detecting |=> out_o.valid && !out_o.pwm_update)
    else $error("sensing tick produced a pwm update");

  // duty never exceeds the clamp ceiling
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.pwm_duty <= bsar_pkg::DutyLimit)
    else $error("pwm duty above limit");

  // torque angle is one of three values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.motor_action == bsar_pkg::TorqueAngle) ||
                    (out_o.motor_action == -bsar_pkg::TorqueAngle) ||
                    (out_o.motor_action == 8'sd0))
    else $error("bad torque angle");

  // fault hold never counts above its load value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.fault_hold <= bsar_pkg::FaultHoldLoad)
    else $error("fault hold out of range");

  // a nonzero fault hold forces the motor off on the next result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (state_q.fault_hold != 4'd0) |=> out_o.motor_off)
    else $error("fault hold did not force motor off");

endmodule

/* hdl/bsar_cfg_regs.sv */
`timescale 1ns / 1ps

module bsar_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  bsar_cfg_if.sink          cfg_i,
  output bsar_pkg::cfg_t    cfg_o
);

  bsar_pkg::cfg_t cfg_q;

  // writes are always taken
  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  // register file, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      case (bsar_pkg::cfg_idx_e'(cfg_i.index))
        bsar_pkg::CFG_TARGET_SPEED: cfg_q.target_speed <= cfg_i.data;
        bsar_pkg::CFG_TARGET_ACCEL: cfg_q.target_accel <= cfg_i.data;
        bsar_pkg::CFG_ACCEL_MODE:   cfg_q.accel_mode   <= cfg_i.data[0];
        bsar_pkg::CFG_AUTO_ROTATE:  cfg_q.auto_rotate  <= cfg_i.data[0];
        bsar_pkg::CFG_IGNORE_FAULT: cfg_q.ignore_fault <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

endmodule

/* hdl/bsar_datapath.sv */
`timescale 1ns / 1ps

module bsar_datapath (
  input  bsar_pkg::cfg_t    cfg_i,
  input  bsar_pkg::state_t  state_i,
  input  logic [15:0]       position_i,
  input  logic              sensor_detecting_i,
  input  logic              fault_event_i,
  input  logic              fault_line_low_i,
  output bsar_pkg::state_t  state_o,
  output bsar_pkg::result_t result_o
);

  logic signed [15:0] pos_delta;
  logic [20:0]        pos_delta_ext;
  logic signed [20:0] speed_shift;
  logic [20:0]        speed_acc_new;
  logic signed [15:0] accel_shift;
  logic [15:0]        speed_delta;
  logic [15:0]        accel_acc_new;
  logic [5:0]         stall_new;
  logic [3:0]         fault_loaded;
  logic               fault_off;
  logic [16:0]        speed_full;
  logic [11:0]        accel_full;
  logic [17:0]        accel_diff;
  logic [17:0]        err;
  logic [17:0]        err_abs;
  logic [13:0]        lim_signed;
  logic [13:0]        lim_abs;
  logic [14:0]        lim_sum;
  logic [7:0]         lim;
  logic [20:0]        mag;

  // averaging terms, floor shift by four
  assign speed_shift = state_i.speed_acc >>> 4;
  assign accel_shift = state_i.accel_acc >>> 4;

  // position delta wraps to 16 bits
  assign pos_delta     = position_i - state_i.last_position;
  assign pos_delta_ext = {{5{pos_delta[15]}}, pos_delta};
  assign speed_acc_new = state_i.speed_acc + pos_delta_ext - speed_shift;

  // acceleration from the low half of the speed accumulator
  assign speed_delta   = speed_acc_new[15:0] - state_i.last_speed_low;
  assign accel_acc_new = state_i.accel_acc + speed_delta - accel_shift;

  // fault hold load and countdown
  always_comb begin
    fault_loaded = (fault_event_i && !cfg_i.ignore_fault) ? bsar_pkg::FaultHoldLoad
                                                          : state_i.fault_hold;
    fault_off    = (fault_loaded != 4'd0);
  end

  // stall countdown; movement ORs in the reload value
  always_comb begin
    stall_new = (state_i.stall_count != 6'd0) ? state_i.stall_count - 6'd1
                                              : state_i.stall_count;
    if (pos_delta != 16'sd0) begin
      stall_new = stall_new | bsar_pkg::StallReload;
    end
  end

  // averaged speed and acceleration shown on the result
  always_comb begin
    if (sensor_detecting_i) begin
      speed_full = state_i.speed_acc[20:4];
      accel_full = state_i.accel_acc[15:4];
    end else begin
      speed_full = speed_acc_new[20:4];
      accel_full = accel_acc_new[15:4];
    end
  end

  // regulation error, wide enough that nothing wraps
  always_comb begin
    accel_diff = {{2{cfg_i.target_accel[15]}}, cfg_i.target_accel}
               - {{6{accel_full[11]}}, accel_full};
    if (cfg_i.accel_mode) begin
      err = {accel_diff[16:0], 1'b0};
    end else begin
      err = {{2{cfg_i.target_speed[15]}}, cfg_i.target_speed}
          - {speed_full[16], speed_full};
    end
    err_abs = err[17] ? (18'd0 - err) : err;
  end

  // speed dependent duty limit and clamped magnitude
  always_comb begin
    lim_signed = speed_full[16:3];
    lim_abs    = lim_signed[13] ? (14'd0 - lim_signed) : lim_signed;
    lim_sum    = {1'b0, lim_abs} + {7'd0, bsar_pkg::DutyBase};
    lim        = (lim_sum > {7'd0, bsar_pkg::DutyLimit}) ? bsar_pkg::DutyLimit
                                                         : lim_sum[7:0];
    mag        = {err_abs, 3'b000};
  end

  // next state and result
  always_comb begin
    state_o = state_i;
    state_o.fault_hold = (fault_off && !(fault_line_low_i && !cfg_i.ignore_fault))
                       ? fault_loaded - 4'd1 : fault_loaded;

    result_o              = '0;
    result_o.motor_off    = fault_off;
    result_o.speed        = speed_full[15:0];
    result_o.accel        = {{4{accel_full[11]}}, accel_full};

    if (!sensor_detecting_i) begin
      state_o.last_position  = position_i;
      state_o.speed_acc      = speed_acc_new;
      state_o.last_speed_low = speed_acc_new[15:0];
      state_o.accel_acc      = accel_acc_new;
      state_o.stall_count    = stall_new;

      result_o.pwm_update = 1'b1;
      result_o.kick_step  = (cfg_i.target_speed != 16'sd0) && (stall_new == 6'd0)
                          && !cfg_i.auto_rotate;
      result_o.pwm_duty   = (mag > {13'd0, lim}) ? lim : mag[7:0];
      if (err[17]) begin
        result_o.motor_action = -bsar_pkg::TorqueAngle;
      end else if (err != 18'd0) begin
        result_o.motor_action = bsar_pkg::TorqueAngle;
      end
    end
  end

endmodule

/* hdl/bsar_out_stage.sv */
`timescale 1ns / 1ps

module bsar_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  bsar_pkg::result_t result_i,
  output logic              ready_o,
  bsar_out_if.source        out_o
);

  logic              valid_q;
  bsar_pkg::result_t result_q;

  // a new transaction may enter when the stage is empty or the held one leaves
  assign ready_o = !valid_q || out_o.ready;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.pwm_update   = result_q.pwm_update;
  assign out_o.pwm_duty     = result_q.pwm_duty;
  assign out_o.motor_action = result_q.motor_action;
  assign out_o.kick_step    = result_q.kick_step;
  assign out_o.motor_off    = result_q.motor_off;
  assign out_o.speed        = result_q.speed;
  assign out_o.accel        = result_q.accel;

endmodule

/* tb/sv/bldc_speed_accel_regulator_test.sv */
`timescale 1ns / 1ps

module bldc_speed_accel_regulator_test;

  localparam int WatchdogLimit = 1000;
  localparam int PhaseTicks    = 150;
  localparam int NumPhases     = 8;

  // kinds of rotor motion the random stimulus strings together
  typedef enum int {
    MOVE_STILL,
    MOVE_CRUISE,
    MOVE_RAMP,
    MOVE_NOISE
  } motion_e;

  // receiver back-pressure patterns
  typedef enum int {
    SINK_ALWAYS,
    SINK_RANDOM,
    SINK_PERIODIC
  } sink_mode_e;

  // tick predictor and result checker
  class tick_scoreboard;
    bsar_pkg::cfg_t     setting;
    logic [15:0]        last_pos;
    logic signed [20:0] speed_acc;
    logic [15:0]        last_speed_low;
    logic signed [15:0] accel_acc;
    logic [5:0]         stall_count;
    logic [3:0]         fault_hold;
    bsar_pkg::result_t  predicted_results[$];
    int                 mismatches;
    int                 results_seen;

    function new();
      setting        = '0;
      last_pos       = '0;
      speed_acc      = '0;
      last_speed_low = '0;
      accel_acc      = '0;
      stall_count    = '0;
      fault_hold     = '0;
      mismatches     = 0;
      results_seen   = 0;
    endfunction

    function int pending();
      return predicted_results.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    function void load_register(bsar_pkg::cfg_idx_e idx, logic [15:0] data);
      case (idx)
        bsar_pkg::CFG_TARGET_SPEED: setting.target_speed = data;
        bsar_pkg::CFG_TARGET_ACCEL: setting.target_accel = data;
        bsar_pkg::CFG_ACCEL_MODE:   setting.accel_mode   = data[0];
        bsar_pkg::CFG_AUTO_ROTATE:  setting.auto_rotate  = data[0];
        bsar_pkg::CFG_IGNORE_FAULT: setting.ignore_fault = data[0];
        default: ;
      endcase
    endfunction

    // advance the predicted state by one accepted tick
    function void note_tick(logic [15:0] pos, logic sensing, logic fault_ev, logic fault_low);
      bsar_pkg::result_t  r;
      logic signed [15:0] delta;
      logic signed [15:0] speed_step;
      int                 acc_next;
      int                 spd;
      int                 acc;
      longint             err;
      longint             lim;
      longint             mag;
      r = '0;

      // fault hold: load on event, count down unless the line stays low
      if (fault_ev && !setting.ignore_fault) fault_hold = bsar_pkg::FaultHoldLoad;
      if (fault_hold != 0) begin
        r.motor_off = 1'b1;
        if (!(fault_low && !setting.ignore_fault)) fault_hold = fault_hold - 4'd1;
      end

      if (!sensing) begin
        // speed average over the wrapped position delta
        delta     = pos - last_pos;
        last_pos  = pos;
        acc_next  = int'(speed_acc) + int'(delta) - (int'(speed_acc) >>> 4);
        speed_acc = acc_next[20:0];

        // stall countdown and kick request
        if (stall_count != 0) stall_count = stall_count - 6'd1;
        if (delta != 0) stall_count = stall_count | bsar_pkg::StallReload;
        r.kick_step = (setting.target_speed != 0) && (stall_count == 0) &&
                      !setting.auto_rotate;

        // acceleration average over the 16-bit speed accumulator delta
        speed_step     = speed_acc[15:0] - last_speed_low;
        last_speed_low = speed_acc[15:0];
        acc_next       = int'(accel_acc) + int'(speed_step) - (int'(accel_acc) >>> 4);
        accel_acc      = acc_next[15:0];
      end

      spd = int'(speed_acc) >>> 4;
      acc = int'(accel_acc) >>> 4;

      if (!sensing) begin
        if (setting.accel_mode) err = (longint'(setting.target_accel) - acc) * 2;
        else err = longint'(setting.target_speed) - spd;

        if (err < 0) r.motor_action = -bsar_pkg::TorqueAngle;
        else if (err > 0) r.motor_action = bsar_pkg::TorqueAngle;
        else r.motor_action = '0;

        // duty clamp grows with speed
        lim = longint'(spd >>> 3);
        if (lim < 0) lim = -lim;
        lim = lim + longint'(bsar_pkg::DutyBase);
        if (lim > longint'(bsar_pkg::DutyLimit)) lim = longint'(bsar_pkg::DutyLimit);
        mag = err * 8;
        if (mag < 0) mag = -mag;
        if (mag > lim) mag = lim;
        r.pwm_duty   = mag[7:0];
        r.pwm_update = 1'b1;
      end

      r.speed = spd[15:0];
      r.accel = acc[15:0];
      predicted_results.push_back(r);
    endfunction

    task check_field(string name, logic signed [31:0] got, logic signed [31:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got %0d, expected %0d",
                         results_seen, name, got, want));
    endtask

    task check_result(bsar_pkg::result_t got);
      bsar_pkg::result_t want;
      results_seen++;
      if (predicted_results.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", results_seen));
        return;
      end
      want = predicted_results.pop_front();
      check_field("pwm_update", got.pwm_update, want.pwm_update);
      check_field("pwm_duty", got.pwm_duty, want.pwm_duty);
      check_field("motor_action", got.motor_action, want.motor_action);
      check_field("kick_step", got.kick_step, want.kick_step);
      check_field("motor_off", got.motor_off, want.motor_off);
      check_field("speed", got.speed, want.speed);
      check_field("accel", got.accel, want.accel);
    endtask

    task flush_leftovers();
      while (predicted_results.size() != 0) begin
        report($sformatf("result for tick %0d never arrived", results_seen + 1));
        void'(predicted_results.pop_front());
        results_seen++;
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  bsar_cfg_if cfg_bus ();
  bsar_in_if  tick_bus ();
  bsar_out_if result_bus ();

  bldc_speed_accel_regulator i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_bus),
    .in_i  (tick_bus),
    .out_o (result_bus)
  );

  tick_scoreboard sb = new();

  int          idle_cycles = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;
  motion_e     motion = MOVE_STILL;
  int          seg_left = 0;
  int          vel = 0;
  logic [15:0] cur_pos = '0;
  logic        fline_state = 1'b0;

  // clock
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // monitor: every accepted transaction on all three channels, plus watchdog
  always @(posedge clk_i) begin : monitor
    bsar_pkg::result_t got;
    logic              moved;
    moved = 1'b0;
    if (cfg_bus.valid && cfg_bus.ready) begin
      sb.load_register(bsar_pkg::cfg_idx_e'(cfg_bus.index), cfg_bus.data);
      moved = 1'b1;
    end
    if (tick_bus.valid && tick_bus.ready) begin
      sb.note_tick(tick_bus.position, tick_bus.sensor_detecting, tick_bus.fault_event,
                   tick_bus.fault_line_low);
      moved = 1'b1;
    end
    if (result_bus.valid && result_bus.ready) begin
      got = '{result_bus.pwm_update, result_bus.pwm_duty, result_bus.motor_action,
              result_bus.kick_step, result_bus.motor_off, result_bus.speed,
              result_bus.accel};
      sb.check_result(got);
      moved = 1'b1;
    end
    if (moved || !rst_ni) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("bldc_speed_accel_regulator_test: FAIL");
      $finish;
    end
  end

  // receiver back-pressure, switching to a randomly chosen pattern as the run goes on
  initial begin : sink_stall
    int         cyc;
    sink_mode_e mode;
    cyc  = 0;
    mode = SINK_RANDOM;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc % 256 == 0) mode = sink_mode_e'($urandom_range(0, 2));
      case (mode)
        SINK_ALWAYS:   result_bus.ready <= 1'b1;
        SINK_RANDOM:   result_bus.ready <= ($urandom_range(0, 3) != 0);
        SINK_PERIODIC: result_bus.ready <= (cyc % 5 >= 2);
        default:       result_bus.ready <= 1'b1;
      endcase
    end
  end

  // one register write transaction, valid left high for the next one
  task automatic write_reg(bsar_pkg::cfg_idx_e idx, logic [15:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
  endtask

  // hold off ticks until every predicted result has been matched
  task automatic drain_results();
    tick_bus.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic apply_setting(logic [15:0] ts, logic [15:0] ta, logic am, logic ar,
                               logic ig);
    drain_results();
    write_reg(bsar_pkg::CFG_TARGET_SPEED, ts);
    write_reg(bsar_pkg::CFG_TARGET_ACCEL, ta);
    write_reg(bsar_pkg::CFG_ACCEL_MODE, {15'd0, am});
    write_reg(bsar_pkg::CFG_AUTO_ROTATE, {15'd0, ar});
    write_reg(bsar_pkg::CFG_IGNORE_FAULT, {15'd0, ig});
    cfg_bus.valid <= 1'b0;
  endtask

  // one tick transaction; bursts of random length, with random gaps between while gaps are on
  task automatic send_tick(logic [15:0] pos, logic sens, logic fev, logic fline);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
        tick_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    tick_bus.valid            <= 1'b1;
    tick_bus.position         <= pos;
    tick_bus.sensor_detecting <= sens;
    tick_bus.fault_event      <= fev;
    tick_bus.fault_line_low   <= fline;
    @(posedge clk_i);
    while (!tick_bus.ready) @(posedge clk_i);
  endtask

  function automatic int random_velocity();
    int mag;
    mag = $urandom_range(0, (1 << $urandom_range(0, 15)) - 1);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  function automatic logic [15:0] random_target();
    case ($urandom_range(0, 3))
      0:       return 16'd0;
      1:       return 16'($urandom);
      default: return 16'(int'($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  // rotor motion in segments: standing still long enough to stall, cruising,
  // ramping, or jumping around
  task automatic random_tick();
    logic sens;
    logic fev;
    if (seg_left == 0) begin
      motion   = motion_e'($urandom_range(0, 3));
      seg_left = (motion == MOVE_STILL) ? $urandom_range(35, 60) : $urandom_range(5, 40);
      vel      = random_velocity();
    end
    seg_left--;
    case (motion)
      MOVE_CRUISE: cur_pos = cur_pos + 16'(vel);
      MOVE_RAMP: begin
        vel     = vel + int'($urandom_range(0, 128)) - 64;
        cur_pos = cur_pos + 16'(vel);
      end
      MOVE_NOISE: cur_pos = 16'($urandom);
      default: ;
    endcase
    if ($urandom_range(0, 29) == 0) fline_state = !fline_state;
    fev  = ($urandom_range(0, 24) == 0);
    sens = ($urandom_range(0, 9) == 0);
    send_tick(cur_pos, sens, fev, fline_state);
  endtask

  // main sequence
  initial begin
    rst_ni                    <= 1'b0;
    cfg_bus.valid             <= 1'b0;
    cfg_bus.index             <= bsar_pkg::CFG_TARGET_SPEED;
    cfg_bus.data              <= '0;
    tick_bus.valid            <= 1'b0;
    tick_bus.position         <= '0;
    tick_bus.sensor_detecting <= 1'b0;
    tick_bus.fault_event      <= 1'b0;
    tick_bus.fault_line_low   <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // speed mode: stall kick, position wrap extremes, sensing, fault hold
    apply_setting(16'd100, 16'd0, 1'b0, 1'b0, 1'b0);
    send_tick(16'h0000, 1'b0, 1'b0, 1'b0);
    send_tick(16'h0040, 1'b0, 1'b0, 1'b0);
    send_tick(16'h0080, 1'b0, 1'b0, 1'b0);
    send_tick(16'h8080, 1'b0, 1'b0, 1'b0);
    send_tick(16'h0081, 1'b0, 1'b0, 1'b0);
    send_tick(16'h7FFF, 1'b0, 1'b0, 1'b0);
    send_tick(16'hFFFF, 1'b0, 1'b0, 1'b0);
    send_tick(16'h0000, 1'b0, 1'b0, 1'b0);
    send_tick(16'h1234, 1'b1, 1'b0, 1'b0);
    send_tick(16'h1234, 1'b0, 1'b0, 1'b0);
    send_tick(16'h1240, 1'b0, 1'b1, 1'b1);
    send_tick(16'h1250, 1'b0, 1'b0, 1'b1);
    send_tick(16'h1260, 1'b1, 1'b0, 1'b0);
    send_tick(16'h1270, 1'b0, 1'b1, 1'b0);

    // accel mode at the negative extremes, faults and kicks disabled
    apply_setting(16'h8000, 16'h8000, 1'b1, 1'b1, 1'b1);
    send_tick(16'h0800, 1'b0, 1'b1, 1'b1);
    send_tick(16'h1000, 1'b0, 1'b0, 1'b1);
    send_tick(16'h1800, 1'b0, 1'b0, 1'b0);
    send_tick(16'h2000, 1'b0, 1'b0, 1'b0);
    send_tick(16'h2000, 1'b0, 1'b0, 1'b0);

    // accel mode at the positive extremes
    apply_setting(16'h7FFF, 16'h7FFF, 1'b1, 1'b0, 1'b0);
    send_tick(16'hA000, 1'b0, 1'b0, 1'b0);
    send_tick(16'h2000, 1'b0, 1'b0, 1'b0);
    send_tick(16'h2000, 1'b1, 1'b1, 1'b0);
    send_tick(16'h2001, 1'b0, 1'b0, 1'b0);

    // random phases, each under its own setting
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: apply_setting(16'h7FFF, 16'h0000, 1'b0, 1'b0, 1'b0);
        1: apply_setting(16'h8000, 16'h7FFF, 1'b1, 1'b1, 1'b1);
        2: apply_setting(16'h0000, 16'h8000, 1'b1, 1'b0, 1'b0);
        3: apply_setting(16'h0001, 16'h0000, 1'b0, 1'b0, 1'b1);
        default: apply_setting(random_target(), random_target(), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      endcase
      gaps_on = (ph % 3 != 2);
      repeat (PhaseTicks) random_tick();
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    sb.flush_leftovers();
    if (sb.mismatches == 0) $display("bldc_speed_accel_regulator_test: PASS");
    else $display("bldc_speed_accel_regulator_test: FAIL");
    $finish;
  end

endmodule
